### rtl/bcs_pkg.sv
package bcs_pkg;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_BEGIN = 2'd1,
		OP_STEP  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		CFG_MAP_WIDTH  = 3'd0,
		CFG_MAP_HEIGHT = 3'd1,
		CFG_MOVE_STEP  = 3'd2,
		CFG_START_X    = 3'd3,
		CFG_START_Y    = 3'd4,
		CFG_FREE_VALUE = 3'd5
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NREAD,
		ST_DECIDE,
		ST_MOD,
		ST_SCAN,
		ST_JUMP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [7:0] pos_x;
		logic [7:0] pos_y;
		logic       jumped;
		logic       finished;
	} result_t;

	localparam int             DIST_W      = 14;
	localparam logic [DIST_W-1:0] NO_DISTANCE = 14'd10000;
	localparam int             NB_COUNT    = 4;

endpackage

### rtl/bcs_ram.sv
module bcs_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/boustrophedon_coverage_stepper.sv
// Coverage stepper: a map is loaded one cell per request (opcode 0), begin (opcode 1)
// places the robot at the start cell, and each step (opcode 2) marks the current cell
// covered and moves one interval to a free neighbor or jumps to the nearest uncovered
// grid-aligned cell, or reports finished when none is left. The free map lives in a
// single one-bit memory with one read and one write port, and that read port sets
// the timing. A step that moves reads the four neighbors, decides and hands off the
// result. A step that has to jump adds the remainder computation, a scan of every
// grid-aligned cell inside the used area at one cell per cycle, a pipeline drain and
// the taking of the target. Map cells read before they are loaded return undefined
// data; there is no clearing pass after reset. A new request is taken while the
// previous result still waits in the output register.
module boustrophedon_coverage_stepper #(
	parameter int MAP_SIDE = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// cell_x, cell_y, cell_value
	input  logic [23:0] s_tdata,
	// opcode
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// pos_x, pos_y
	output logic [15:0] m_tdata,
	// jumped, finished
	output logic [1:0]  m_tuser
);

	import bcs_pkg::*;

	localparam int CW    = ($clog2(MAP_SIDE) > 8) ? $clog2(MAP_SIDE) : 8;
	localparam int SW    = CW + 2;
	localparam int DEPTH = MAP_SIDE * MAP_SIDE;
	localparam int AW    = $clog2(DEPTH);

	state_t state_q, state_d;

	logic [8:0] map_width_q, map_height_q;
	logic [7:0] move_step_q, start_x_q, start_y_q, free_value_q;

	logic [CW-1:0] cur_x_q, cur_y_q;
	logic          done_q;

	logic [2:0]    idx_q;
	logic          nvld_s1, ninmap_s1;
	logic [1:0]    nidx_s1;
	logic [NB_COUNT-1:0] f_q;

	logic [2:0]    bit_q;
	logic [7:0]    rem_x_q, rem_y_q;

	logic signed [SW-1:0] sx_q, sy_q, sy0_q, sx_s1, sy_s1;
	logic                 issue_q, svld_s1;
	logic [DIST_W-1:0]    best_q;
	logic [CW-1:0]        bx_q, by_q;

	result_t res_q, out_q;
	logic    out_vld_q;

	logic          acc, out_free;
	op_t           op;
	logic [7:0]    in_x, in_y, in_val, m;
	logic signed [SW-1:0] uw, uh, ms, cxs, cys, nx, ny, mvx, mvy, ny_adv, nx_adv, dx, dy;
	logic          in_map, mv, hit, found;
	logic [8:0]    tx, ty;
	logic [7:0]    rx_next, ry_next;
	logic [DIST_W-1:0] manh_d;

	logic          mem_we, mem_wdata, mem_rdata;
	logic [AW-1:0] mem_waddr, mem_raddr;

	function automatic logic [AW-1:0] addr_of(input logic [SW-1:0] x, input logic [SW-1:0] y);
		return AW'(32'(y) * MAP_SIDE + 32'(x));
	endfunction

	assign acc      = s_tvalid && s_tready;
	assign op       = op_t'(s_tuser);
	assign in_x     = s_tdata[7:0];
	assign in_y     = s_tdata[15:8];
	assign in_val   = s_tdata[23:16];
	assign out_free = !out_vld_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);

	assign m        = (move_step_q == 8'd0) ? 8'd1 : move_step_q;
	assign ms       = SW'(m);
	assign uw       = (32'(map_width_q) < MAP_SIDE) ? SW'(map_width_q) : SW'(MAP_SIDE);
	assign uh       = (32'(map_height_q) < MAP_SIDE) ? SW'(map_height_q) : SW'(MAP_SIDE);
	assign cxs      = SW'(cur_x_q);
	assign cys      = SW'(cur_y_q);

	always_comb begin
		nx = cxs;
		ny = cys;
		case (idx_q[1:0])
			2'd0: ny = cys + ms;
			2'd1: ny = cys - ms;
			2'd2: nx = cxs - ms;
			default: nx = cxs + ms;
		endcase
		in_map = (nx >= 0) && (ny >= 0) && (nx < uw) && (ny < uh);
	end

	always_comb begin
		mv  = 1'b1;
		mvx = cxs;
		mvy = cys;
		if ((f_q[0] && f_q[2]) || (f_q[1] && f_q[2])) begin
			mvx = cxs - ms;
		end else if (f_q[1] && f_q[0]) begin
			mvy = cys + ms;
		end else if (f_q[1]) begin
			mvy = cys - ms;
		end else if (f_q[0]) begin
			mvy = cys + ms;
		end else if (f_q[2]) begin
			mvx = cxs - ms;
		end else if (f_q[3]) begin
			mvx = cxs + ms;
		end else begin
			mv = 1'b0;
		end
	end

	always_comb begin
		tx      = {rem_x_q, start_x_q[bit_q]};
		ty      = {rem_y_q, start_y_q[bit_q]};
		rx_next = (tx >= {1'b0, m}) ? 8'(tx - {1'b0, m}) : tx[7:0];
		ry_next = (ty >= {1'b0, m}) ? 8'(ty - {1'b0, m}) : ty[7:0];
	end

	assign ny_adv = sy_q + ms;
	assign nx_adv = sx_q + ms;
	assign dx     = (cxs >= sx_s1) ? (cxs - sx_s1) : (sx_s1 - cxs);
	assign dy     = (cys >= sy_s1) ? (cys - sy_s1) : (sy_s1 - cys);
	assign manh_d = DIST_W'(dx) + DIST_W'(dy);
	assign hit    = svld_s1 && mem_rdata && (manh_d < best_q);
	assign found  = (best_q != NO_DISTANCE);

	always_comb begin
		mem_we    = 1'b0;
		mem_wdata = 1'b0;
		mem_waddr = addr_of(SW'(cur_x_q), SW'(cur_y_q));
		if (acc && op == OP_LOAD) begin
			mem_we    = (32'(in_x) < MAP_SIDE) && (32'(in_y) < MAP_SIDE);
			mem_wdata = (in_val == free_value_q);
			mem_waddr = addr_of(SW'(in_x), SW'(in_y));
		end else if (acc && op == OP_STEP) begin
			mem_we = !done_q && (32'(cur_x_q) < MAP_SIDE) && (32'(cur_y_q) < MAP_SIDE);
		end
		mem_raddr = (state_q == ST_NREAD) ? addr_of(nx, ny) : addr_of(sx_q, sy_q);
	end

	bcs_ram #(
		.WIDTH(1),
		.DEPTH(DEPTH)
	) u_map (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					case (op)
						OP_BEGIN: state_d = ST_EMIT;
						OP_STEP:  state_d = done_q ? ST_EMIT : ST_NREAD;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_NREAD:  if (idx_q == 3'(NB_COUNT)) state_d = ST_DECIDE;
			ST_DECIDE: state_d = mv ? ST_EMIT : ST_MOD;
			ST_MOD:    if (bit_q == 3'd0) state_d = ST_SCAN;
			ST_SCAN:   if (!issue_q && !svld_s1) state_d = ST_JUMP;
			ST_JUMP:   state_d = ST_EMIT;
			ST_EMIT:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q  <= 9'd256;
			map_height_q <= 9'd256;
			move_step_q  <= 8'd1;
			start_x_q    <= 8'd0;
			start_y_q    <= 8'd0;
			free_value_q <= 8'd255;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAP_WIDTH:  map_width_q  <= cfg_data;
				CFG_MAP_HEIGHT: map_height_q <= cfg_data;
				CFG_MOVE_STEP:  move_step_q  <= cfg_data[7:0];
				CFG_START_X:    start_x_q    <= cfg_data[7:0];
				CFG_START_Y:    start_y_q    <= cfg_data[7:0];
				CFG_FREE_VALUE: free_value_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q   <= '0;
			cur_y_q   <= '0;
			done_q    <= 1'b0;
			idx_q     <= '0;
			nvld_s1   <= 1'b0;
			bit_q     <= '0;
			issue_q   <= 1'b0;
			svld_s1   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc && op == OP_BEGIN) begin
						cur_x_q <= CW'(start_x_q);
						cur_y_q <= CW'(start_y_q);
						done_q  <= 1'b0;
					end
					idx_q <= '0;
				end
				ST_NREAD: begin
					nvld_s1 <= (idx_q != 3'(NB_COUNT));
					if (idx_q != 3'(NB_COUNT)) begin
						idx_q <= idx_q + 3'd1;
					end
				end
				ST_DECIDE: begin
					if (mv) begin
						cur_x_q <= CW'(mvx);
						cur_y_q <= CW'(mvy);
					end
					bit_q <= 3'd7;
				end
				ST_MOD: begin
					bit_q <= bit_q - 3'd1;
					if (bit_q == 3'd0) begin
						issue_q <= (SW'(rx_next) < uw) && (SW'(ry_next) < uh);
					end
				end
				ST_SCAN: begin
					svld_s1 <= issue_q;
					if (issue_q && !(ny_adv < uh) && !(nx_adv < uw)) begin
						issue_q <= 1'b0;
					end
				end
				ST_JUMP: begin
					if (found) begin
						cur_x_q <= bx_q;
						cur_y_q <= by_q;
					end else begin
						done_q <= 1'b1;
					end
				end
				default: ;
			endcase
			if (state_q == ST_EMIT && out_free) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (acc && op == OP_BEGIN) begin
					res_q <= '{pos_x: start_x_q, pos_y: start_y_q, jumped: 1'b0, finished: 1'b0};
				end else if (acc && op == OP_STEP) begin
					res_q <= '{pos_x: 8'(cur_x_q), pos_y: 8'(cur_y_q), jumped: 1'b0,
						finished: 1'b1};
				end
			end
			ST_NREAD: begin
				nidx_s1   <= idx_q[1:0];
				ninmap_s1 <= in_map;
				if (nvld_s1) begin
					f_q[nidx_s1] <= ninmap_s1 && mem_rdata;
				end
			end
			ST_DECIDE: begin
				res_q   <= '{pos_x: 8'(mvx), pos_y: 8'(mvy), jumped: 1'b0, finished: 1'b0};
				rem_x_q <= '0;
				rem_y_q <= '0;
			end
			ST_MOD: begin
				rem_x_q <= rx_next;
				rem_y_q <= ry_next;
				sx_q    <= SW'(rx_next);
				sy_q    <= SW'(ry_next);
				sy0_q   <= SW'(ry_next);
				best_q  <= NO_DISTANCE;
			end
			ST_SCAN: begin
				if (issue_q) begin
					sx_s1 <= sx_q;
					sy_s1 <= sy_q;
					if (ny_adv < uh) begin
						sy_q <= ny_adv;
					end else begin
						sy_q <= sy0_q;
						sx_q <= nx_adv;
					end
				end
				if (hit) begin
					best_q <= manh_d;
					bx_q   <= CW'(sx_s1);
					by_q   <= CW'(sy_s1);
				end
			end
			ST_JUMP: begin
				if (found) begin
					res_q <= '{pos_x: 8'(bx_q), pos_y: 8'(by_q), jumped: 1'b1, finished: 1'b0};
				end else begin
					res_q <= '{pos_x: 8'(cur_x_q), pos_y: 8'(cur_y_q), jumped: 1'b0,
						finished: 1'b1};
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					out_q <= res_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {out_q.pos_y, out_q.pos_x};
	assign m_tuser  = {out_q.finished, out_q.jumped};

`ifndef SYNTHESIS
	// The map memory is written only when a request is taken in the idle state.
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_IDLE))
		else $error("map write outside idle");

	// Scan read data is only consumed while the scan is running.
	a_scan_stage: assert property (@(posedge clk) disable iff (!arst_n)
		svld_s1 |-> (state_q == ST_SCAN))
		else $error("scan stage valid outside scan");

	// A result is never both a jump and a finish.
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("jumped and finished both set");

	// Once finished is reported, the stepper stays done until the next begin.
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && !(acc && op == OP_BEGIN)) |=> done_q)
		else $error("done flag dropped without begin");
`endif

endmodule

### tb/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import bcs_pkg::*;

	localparam int SIDE = 256;
	localparam int ITEMS = 1200;
	localparam int WATCHDOG = 5000;
	localparam int HOLD_OFF = 400;
	localparam int SETTLE = 40;
	localparam int TAIL = 300;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct {
		logic [1:0] op;
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] v;
		bit         fixed;
		result_t    res;
	} request_t;

	typedef struct {
		bit       is_cfg;
		cfg_idx_t idx;
		logic [8:0] val;
		request_t req;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [8:0]  cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;

	boustrophedon_coverage_stepper #(.MAP_SIDE(SIDE)) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	bit         free_map [SIDE][SIDE];
	logic [8:0] map_w = 9'd256;
	logic [8:0] map_h = 9'd256;
	logic [7:0] grid_step = 8'd1;
	logic [7:0] start_x = 8'd0;
	logic [7:0] start_y = 8'd0;
	logic [7:0] free_code = 8'd255;
	logic [7:0] rob_x = 8'd0;
	logic [7:0] rob_y = 8'd0;
	bit         finished_r = 1'b0;

	request_t req_q [$];
	request_t cur_req;
	result_t  expected_moves [$];
	row_t     directed_rows [$];
	bit       s_took = 1'b0;
	int       n_pushed = 0;
	int       n_taken = 0;
	int       errors = 0;
	int       idle_cycles = 0;
	int       send_pct = 0;
	int       recv_pct = 0;
	bit       hold_go = 1'b0;
	bit       holding = 1'b0;

	function automatic int span(logic [8:0] v);
		return (int'(v) < SIDE) ? int'(v) : SIDE;
	endfunction

	function automatic bit cell_open(int x, int y);
		if (x < 0 || y < 0 || x >= span(map_w) || y >= span(map_h))
			return 1'b0;
		return free_map[y][x];
	endfunction

	function automatic bit predict_request(input request_t rq, output result_t res);
		int m, cx, cy, best, bx, by, d;
		bit s, n, w, e, moved, found, jumped;
		res = '0;
		jumped = 1'b0;
		case (rq.op)
			OP_LOAD: begin
				free_map[rq.y][rq.x] = (rq.v == free_code);
				return 1'b0;
			end
			OP_BEGIN: begin
				rob_x = start_x;
				rob_y = start_y;
				finished_r = 1'b0;
			end
			OP_STEP: begin
				if (!finished_r) begin
					free_map[rob_y][rob_x] = 1'b0;
					m = (grid_step == 8'd0) ? 1 : int'(grid_step);
					cx = int'(rob_x);
					cy = int'(rob_y);
					s = cell_open(cx, cy + m);
					n = cell_open(cx, cy - m);
					w = cell_open(cx - m, cy);
					e = cell_open(cx + m, cy);
					moved = 1'b1;
					if ((s && w) || (n && w)) cx -= m;
					else if (n && s) cy += m;
					else if (n) cy -= m;
					else if (s) cy += m;
					else if (w) cx -= m;
					else if (e) cx += m;
					else moved = 1'b0;
					if (moved) begin
						rob_x = 8'(cx);
						rob_y = 8'(cy);
					end else begin
						best = int'(NO_DISTANCE);
						bx = 0;
						by = 0;
						found = 1'b0;
						for (int x = int'(start_x) % m; x < span(map_w); x += m) begin
							for (int y = int'(start_y) % m; y < span(map_h); y += m) begin
								if (cell_open(x, y)) begin
									d = ((cx > x) ? cx - x : x - cx) + ((cy > y) ? cy - y : y - cy);
									if (d < best) begin
										best = d;
										bx = x;
										by = y;
										found = 1'b1;
									end
								end
							end
						end
						if (found) begin
							rob_x = 8'(bx);
							rob_y = 8'(by);
							jumped = 1'b1;
						end else begin
							finished_r = 1'b1;
						end
					end
				end
			end
			default: return 1'b0;
		endcase
		res.pos_x = rob_x;
		res.pos_y = rob_y;
		res.jumped = jumped;
		res.finished = finished_r;
		return 1'b1;
	endfunction

	function automatic request_t make_req(logic [1:0] op, int x, int y, int v);
		request_t rq;
		rq.op = op;
		rq.x = 8'(x);
		rq.y = 8'(y);
		rq.v = 8'(v);
		rq.fixed = 1'b0;
		rq.res = '0;
		return rq;
	endfunction

	task automatic add_item(logic [1:0] op, int x, int y, int v);
		row_t row;
		row.is_cfg = 1'b0;
		row.req = make_req(op, x, y, v);
		directed_rows.insert(directed_rows.size(), row);
	endtask

	task automatic add_fixed(logic [1:0] op, int px, int py, bit j, bit f);
		row_t row;
		row.is_cfg = 1'b0;
		row.req = make_req(op, $urandom, $urandom, $urandom);
		row.req.fixed = 1'b1;
		row.req.res.pos_x = 8'(px);
		row.req.res.pos_y = 8'(py);
		row.req.res.jumped = j;
		row.req.res.finished = f;
		directed_rows.insert(directed_rows.size(), row);
	endtask

	task automatic add_cfg(cfg_idx_t idx, int val);
		row_t row;
		row.is_cfg = 1'b1;
		row.idx = idx;
		row.val = 9'(val);
		directed_rows.insert(directed_rows.size(), row);
	endtask

	task automatic queue_request(request_t rq);
		req_q.insert(req_q.size(), rq);
		n_pushed++;
	endtask

	task automatic settle(int cycles);
		while (!(n_taken == n_pushed && expected_moves.size() == 0))
			@(negedge clk);
		repeat (cycles) @(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, int val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 9'(val);
		case (idx)
			CFG_MAP_WIDTH:  map_w = 9'(val);
			CFG_MAP_HEIGHT: map_h = 9'(val);
			CFG_MOVE_STEP:  grid_step = 8'(val);
			CFG_START_X:    start_x = 8'(val);
			CFG_START_Y:    start_y = 8'(val);
			CFG_FREE_VALUE: free_code = 8'(val);
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk) begin
		result_t r, got;
		s_took = s_tvalid && s_tready;
		if (s_took) begin
			n_taken++;
			if (predict_request(cur_req, r))
				expected_moves.insert(expected_moves.size(), cur_req.fixed ? cur_req.res : r);
		end
		if (m_tvalid && m_tready) begin
			got = '{pos_x: m_tdata[7:0], pos_y: m_tdata[15:8],
				jumped: m_tuser[0], finished: m_tuser[1]};
			if (expected_moves.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual x=%0d y=%0d jumped=%0d finished=%0d",
					$time, got.pos_x, got.pos_y, got.jumped, got.finished);
			end else begin
				r = expected_moves.pop_front();
				if (got !== r) begin
					errors++;
					$display("%0t: expected x=%0d y=%0d jumped=%0d finished=%0d, actual x=%0d y=%0d jumped=%0d finished=%0d",
						$time, r.pos_x, r.pos_y, r.jumped, r.finished,
						got.pos_x, got.pos_y, got.jumped, got.finished);
				end
			end
		end
		if (s_took || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
	end

	always @(negedge clk) begin
		if (!s_tvalid || s_took) begin
			if (req_q.size() != 0 && $urandom_range(0, 99) >= send_pct) begin
				cur_req = req_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {cur_req.v, cur_req.y, cur_req.x};
				s_tuser <= cur_req.op;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		m_tready <= !holding && ($urandom_range(0, 99) >= recv_pct);
	end

	initial begin
		forever begin
			@(posedge clk);
			if (hold_go && expected_moves.size() != 0) begin
				hold_go = 1'b0;
				holding = 1'b1;
				repeat (HOLD_OFF) @(posedge clk);
				holding = 1'b0;
			end
		end
	end

	initial begin
		while (idle_cycles < WATCHDOG)
			@(posedge clk);
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int w, h, m, sx, sy, fv, free_pct, n_ops, r, phase;
		logic [7:0] cv;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		add_fixed(OP_BEGIN, 0, 0, 1'b0, 1'b0);
		add_item(OP_UNUSED, 17, 99, 3);
		add_item(OP_LOAD, 255, 255, 255);
		add_item(OP_LOAD, 0, 0, 0);
		add_cfg(CFG_MAP_WIDTH, 2);
		add_cfg(CFG_MAP_HEIGHT, 1);
		add_cfg(CFG_FREE_VALUE, 0);
		add_item(OP_LOAD, 0, 0, 0);
		add_item(OP_LOAD, 1, 0, 255);
		add_fixed(OP_BEGIN, 0, 0, 1'b0, 1'b0);
		add_fixed(OP_STEP, 0, 0, 1'b0, 1'b1);
		add_fixed(OP_STEP, 0, 0, 1'b0, 1'b1);
		add_fixed(OP_BEGIN, 0, 0, 1'b0, 1'b0);
		add_fixed(OP_STEP, 0, 0, 1'b0, 1'b1);
		add_item(OP_LOAD, 1, 0, 0);
		add_fixed(OP_STEP, 0, 0, 1'b0, 1'b1);
		add_fixed(OP_BEGIN, 0, 0, 1'b0, 1'b0);
		add_fixed(OP_STEP, 1, 0, 1'b0, 1'b0);
		add_item(OP_LOAD, 0, 0, 0);
		add_fixed(OP_STEP, 0, 0, 1'b0, 1'b0);
		add_fixed(OP_STEP, 0, 0, 1'b0, 1'b1);
		add_cfg(CFG_MOVE_STEP, 0);
		add_cfg(CFG_START_X, 200);
		add_item(OP_LOAD, 0, 0, 0);
		add_fixed(OP_BEGIN, 200, 0, 1'b0, 1'b0);
		add_fixed(OP_STEP, 0, 0, 1'b1, 1'b0);
		add_fixed(OP_STEP, 0, 0, 1'b0, 1'b1);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg) begin
				settle(SETTLE);
				write_reg(directed_rows[i].idx, int'(directed_rows[i].val));
			end else begin
				queue_request(directed_rows[i].req);
			end
		end

		phase = 0;
		while (phase < 8 || n_pushed < ITEMS) begin
			w = $urandom_range(1, 10);
			h = $urandom_range(1, 10);
			r = $urandom_range(0, 9);
			m = (r < 6) ? 1 : ((r < 9) ? $urandom_range(2, 3) : $urandom_range(4, 255));
			sx = $urandom_range(0, w - 1);
			sy = $urandom_range(0, h - 1);
			if ($urandom_range(0, 9) == 0) begin
				sx = $urandom_range(0, 255);
				sy = $urandom_range(0, 255);
			end
			fv = $urandom_range(0, 255);
			case (phase)
				0: begin
					w = 256;
					h = 1;
					sx = 255;
					sy = 0;
				end
				1: begin
					w = 1;
					h = 256;
					sx = 0;
					sy = $urandom_range(0, 255);
				end
				2: m = 255;
				3: m = 0;
				4: fv = 0;
				5: begin
					fv = 255;
					sx = 255;
					sy = 255;
				end
				default: ;
			endcase
			free_pct = $urandom_range(50, 90);

			settle(SETTLE);
			write_reg(CFG_MAP_WIDTH, w);
			write_reg(CFG_MAP_HEIGHT, h);
			write_reg(CFG_MOVE_STEP, m);
			write_reg(CFG_START_X, sx);
			write_reg(CFG_START_Y, sy);
			write_reg(CFG_FREE_VALUE, fv);
			send_pct = (phase % 4 == 1) ? 49 : ((phase % 4 == 3) ? 17 : 0);
			recv_pct = (phase % 4 == 2) ? 49 : ((phase % 4 == 3) ? 17 : 0);

			for (int y = 0; y < h; y++) begin
				for (int x = 0; x < w; x++) begin
					cv = ($urandom_range(0, 99) < free_pct) ? 8'(fv) : 8'(fv + $urandom_range(1, 255));
					queue_request(make_req(OP_LOAD, x, y, cv));
				end
			end

			n_ops = (w * h > 50) ? 60 : w * h + 10;
			queue_request(make_req(OP_BEGIN, $urandom, $urandom, $urandom));
			for (int k = 0; k < n_ops; k++) begin
				r = $urandom_range(0, 99);
				cv = ($urandom_range(0, 99) < free_pct) ? 8'(fv) : 8'($urandom);
				if (r < 75)
					queue_request(make_req(OP_STEP, $urandom, $urandom, $urandom));
				else if (r < 80)
					queue_request(make_req(OP_BEGIN, $urandom, $urandom, $urandom));
				else if (r < 90)
					queue_request(make_req(OP_LOAD, $urandom_range(0, w - 1),
						$urandom_range(0, h - 1), cv));
				else if (r < 97)
					queue_request(make_req(OP_LOAD, $urandom, $urandom, cv));
				else
					queue_request(make_req(OP_UNUSED, $urandom, $urandom, $urandom));
			end
			if (phase == 6)
				hold_go = 1'b1;
			phase++;
		end

		settle(TAIL);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### filelist.f
rtl/bcs_pkg.sv
rtl/bcs_ram.sv
rtl/boustrophedon_coverage_stepper.sv
tb/testbench.sv
